>>> design/evte_pkg.sv
// shared types and constants for the eased value tween engine
// no dependencies
package evte_pkg;

   localparam int MAX_RESULTS = 16;
   localparam int FRAC_W      = 16;

   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_TICK  = 2'd1;
   localparam logic [1:0] ACT_SET   = 2'd2;

   typedef struct packed {
      logic [3:0]  target;
      logic [15:0] start_value;
      logic [15:0] end_value;
      logic [31:0] start_time;
      logic [31:0] end_time;
   } slot_type;

   typedef struct packed {
      logic              busy;
      logic [FRAC_W-1:0] quot;
   } div_stat_type;

   typedef enum logic [10:0] {
      S_IDLE   = 11'b000_0000_0001,
      S_RD     = 11'b000_0000_0010,
      S_EVAL   = 11'b000_0000_0100,
      S_DIV    = 11'b000_0000_1000,
      S_MUL1   = 11'b000_0001_0000,
      S_MUL2   = 11'b000_0010_0000,
      S_VAL    = 11'b000_0100_0000,
      S_COMMIT = 11'b000_1000_0000,
      S_EMIT   = 11'b001_0000_0000,
      S_NEW    = 11'b010_0000_0000,
      S_FLUSH  = 11'b100_0000_0000
   } state_type;

endpackage

>>> design/evte_div.sv
// restoring divider giving floor(dt * 2^16 / span) for dt < span, one bit per cycle
// depends on evte_pkg
module evte_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [31:0]              dividend,
   input  logic [31:0]              divisor,
   output evte_pkg::div_stat_type   stat
);

   logic [31:0]                  rem_ff, rem_in;
   logic [evte_pkg::FRAC_W-1:0]  quot_ff, quot_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [32:0]                  shifted;
   logic [31:0]                  div_ff;

   always_comb begin
      shifted = {rem_ff, 1'b0};
      rem_in  = rem_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      if (start) begin
         rem_in  = dividend;
         quot_in = '0;
         cnt_in  = 5'(evte_pkg::FRAC_W);
      end else if (cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         if (shifted >= {1'b0, div_ff}) begin
            rem_in  = 32'(shifted - {1'b0, div_ff});
            quot_in = {quot_ff[evte_pkg::FRAC_W-2:0], 1'b1};
         end else begin
            rem_in  = shifted[31:0];
            quot_in = {quot_ff[evte_pkg::FRAC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      if (start) begin
         div_ff <= divisor;
      end
   end

   assign stat.busy = (cnt_ff != 5'd0);
   assign stat.quot = quot_ff;

endmodule

>>> design/eased_value_tween_engine.sv
// Eased value tween engine: a table of tween slots moving target values with ease-out
// quadratic curves. Depends on evte_pkg and evte_div.
//
// One request at a time. A set request is written on accept. A start request visits
// every slot, then writes a new slot when one is free. A tick visits every slot: a
// slot not advancing is only read and evaluated, a slot that finishes commits its
// end value, and a slot mid-tween first runs the 16-step shared divider and the two
// registered multiplies. A commit with a result already pending first hands the
// previous result to the output register, waiting while the result side stalls;
// results of a tick come out one per cycle at most, the final one with tlast.
module eased_value_tween_engine #(
   parameter int SLOT_COUNT   = 16,
   parameter int TARGET_COUNT = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // target, end_value, duration, now, zero pad
   input  logic [1:0]  req_tuser,   // action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // out_target, out_value, zero pad
   output logic        rsp_tlast
);

   localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CUR_N = (TARGET_COUNT < 16) ? TARGET_COUNT : 16;
   localparam int CUR_W = (CUR_N > 1) ? $clog2(CUR_N) : 1;

   evte_pkg::state_type          state_ff, state_in;
   evte_pkg::slot_type           mem [SLOT_COUNT];
   evte_pkg::slot_type           rd_ff, wr_data;
   logic                         mem_we;
   logic [IDX_W-1:0]             wr_addr;

   logic [SLOT_COUNT-1:0]        busy_ff, busy_in;
   logic [15:0]                  cur_ff [CUR_N];
   logic                         cur_we;
   logic [CUR_W-1:0]             cur_wa;
   logic [15:0]                  cur_wd;

   logic [IDX_W-1:0]             idx_ff, idx_in, free_ff, free_in;
   logic                         found_ff, found_in;
   logic [1:0]                   act_ff;
   logic [3:0]                   tg_ff;
   logic [15:0]                  ev_ff, dur_ff;
   logic [31:0]                  now_ff;

   logic                         pend_ff, pend_in;
   logic [3:0]                   pend_tg_ff, pend_tg_in;
   logic [15:0]                  pend_val_ff, pend_val_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [15:0]                  v_ff, v_in;
   logic [33:0]                  ease_ff, ease_in;
   logic signed [51:0]           p_ff, p_in;

   logic                         out_vld_ff, out_vld_in, out_last_ff, out_last_in;
   logic [3:0]                   out_tg_ff, out_tg_in;
   logic [15:0]                  out_val_ff, out_val_in;

   logic                         div_start;
   evte_pkg::div_stat_type       div_stat;

   logic                         accept, out_free, adv, hit, cut, free_it, still_busy;
   logic [15:0]                  cur;
   logic [31:0]                  new_et, dt, span;
   logic [32:0]                  et_sum;
   logic signed [16:0]           diff;
   logic signed [51:0]           rounded;
   logic [17:0]                  one_minus;

   evte_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dt),
      .divisor  (span),
      .stat     (div_stat)
   );

   assign accept     = req_tvalid && req_tready;
   assign req_tready = (state_ff == evte_pkg::S_IDLE);
   assign out_free   = !out_vld_ff || rsp_tready;
   assign cur        = cur_ff[tg_ff[CUR_W-1:0]];

   always_comb begin
      state_in    = state_ff;
      busy_in     = busy_ff;
      idx_in      = idx_ff;
      free_in     = free_ff;
      found_in    = found_ff;
      pend_in     = pend_ff;
      pend_tg_in  = pend_tg_ff;
      pend_val_in = pend_val_ff;
      cnt_in      = cnt_ff;
      v_in        = v_ff;
      ease_in     = ease_ff;
      p_in        = p_ff;
      out_vld_in  = out_vld_ff && !rsp_tready;
      out_last_in = out_last_ff;
      out_tg_in   = out_tg_ff;
      out_val_in  = out_val_ff;
      mem_we      = 1'b0;
      wr_addr     = idx_ff;
      wr_data     = rd_ff;
      cur_we      = 1'b0;
      cur_wa      = req_tdata[CUR_W-1:0];
      cur_wd      = req_tdata[19:4];
      div_start   = 1'b0;
      adv         = 1'b0;
      dt          = now_ff - rd_ff.start_time;
      span        = rd_ff.end_time - rd_ff.start_time;
      hit         = busy_ff[idx_ff] && (rd_ff.target == tg_ff);
      cut         = rd_ff.end_time > now_ff;
      new_et      = cut ? now_ff : rd_ff.end_time;
      free_it     = (rd_ff.start_time >= now_ff) || (rd_ff.start_time >= new_et);
      still_busy  = busy_ff[idx_ff] && !(hit && free_it);
      et_sum      = {1'b0, now_ff} + {17'd0, dur_ff};
      one_minus   = 18'h20000 - {2'b00, div_stat.quot};
      diff        = $signed({rd_ff.end_value[15], rd_ff.end_value})
                    - $signed({rd_ff.start_value[15], rd_ff.start_value});
      rounded     = p_ff + 52'sh8000_0000;

      case (state_ff)
         evte_pkg::S_IDLE: begin
            if (accept) begin
               idx_in   = '0;
               found_in = 1'b0;
               cnt_in   = '0;
               pend_in  = 1'b0;
               if (req_tuser == evte_pkg::ACT_START && 32'(req_tdata[3:0]) < TARGET_COUNT) begin
                  state_in = evte_pkg::S_RD;
               end else if (req_tuser == evte_pkg::ACT_TICK) begin
                  state_in = evte_pkg::S_RD;
               end else if (req_tuser == evte_pkg::ACT_SET
                            && 32'(req_tdata[3:0]) < TARGET_COUNT) begin
                  cur_we = 1'b1;
               end
            end
         end
         evte_pkg::S_RD: begin
            state_in = evte_pkg::S_EVAL;
         end
         evte_pkg::S_EVAL: begin
            if (act_ff == evte_pkg::ACT_START) begin
               if (hit) begin
                  mem_we            = 1'b1;
                  wr_data.end_time  = new_et;
                  wr_data.end_value = cut ? cur : rd_ff.end_value;
                  busy_in[idx_ff]   = !free_it;
               end
               if (!still_busy && !found_ff) begin
                  found_in = 1'b1;
                  free_in  = idx_ff;
               end
               adv = 1'b1;
            end else if (busy_ff[idx_ff] && now_ff >= rd_ff.start_time) begin
               if (span == 32'd0 || dt >= span) begin
                  v_in            = rd_ff.end_value;
                  busy_in[idx_ff] = 1'b0;
                  state_in        = evte_pkg::S_COMMIT;
               end else begin
                  div_start = 1'b1;
                  state_in  = evte_pkg::S_DIV;
               end
            end else begin
               adv = 1'b1;
            end
         end
         evte_pkg::S_DIV: begin
            if (!div_stat.busy) begin
               state_in = evte_pkg::S_MUL1;
            end
         end
         evte_pkg::S_MUL1: begin
            ease_in  = {18'd0, div_stat.quot} * {16'd0, one_minus};
            state_in = evte_pkg::S_MUL2;
         end
         evte_pkg::S_MUL2: begin
            p_in     = $signed({18'd0, ease_ff}) * 52'(diff);
            state_in = evte_pkg::S_VAL;
         end
         evte_pkg::S_VAL: begin
            v_in     = rd_ff.start_value + rounded[47:32];
            state_in = evte_pkg::S_COMMIT;
         end
         evte_pkg::S_COMMIT: begin
            if (32'(rd_ff.target) < TARGET_COUNT) begin
               cur_we = 1'b1;
               cur_wa = rd_ff.target[CUR_W-1:0];
               cur_wd = v_ff;
            end
            if (32'(cnt_ff) < evte_pkg::MAX_RESULTS) begin
               if (pend_ff) begin
                  state_in = evte_pkg::S_EMIT;
               end else begin
                  pend_in     = 1'b1;
                  pend_tg_in  = rd_ff.target;
                  pend_val_in = v_ff;
                  cnt_in      = cnt_ff + 5'd1;
                  adv         = 1'b1;
               end
            end else begin
               adv = 1'b1;
            end
         end
         evte_pkg::S_EMIT: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_last_in = 1'b0;
               out_tg_in   = pend_tg_ff;
               out_val_in  = pend_val_ff;
               pend_tg_in  = rd_ff.target;
               pend_val_in = v_ff;
               cnt_in      = cnt_ff + 5'd1;
               adv         = 1'b1;
            end
         end
         evte_pkg::S_NEW: begin
            mem_we              = 1'b1;
            wr_addr             = free_ff;
            wr_data.target      = tg_ff;
            wr_data.start_value = cur;
            wr_data.end_value   = ev_ff;
            wr_data.start_time  = now_ff;
            wr_data.end_time    = et_sum[32] ? 32'hFFFF_FFFF : et_sum[31:0];
            busy_in[free_ff]    = 1'b1;
            state_in            = evte_pkg::S_IDLE;
         end
         evte_pkg::S_FLUSH: begin
            if (out_free) begin
               out_vld_in  = 1'b1;
               out_last_in = 1'b1;
               out_tg_in   = pend_tg_ff;
               out_val_in  = pend_val_ff;
               pend_in     = 1'b0;
               state_in    = evte_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = evte_pkg::S_IDLE;
         end
      endcase

      if (adv) begin
         if (idx_ff == IDX_W'(SLOT_COUNT - 1)) begin
            if (act_ff == evte_pkg::ACT_START) begin
               state_in = found_in ? evte_pkg::S_NEW : evte_pkg::S_IDLE;
            end else begin
               state_in = pend_in ? evte_pkg::S_FLUSH : evte_pkg::S_IDLE;
            end
         end else begin
            idx_in   = idx_ff + IDX_W'(1);
            state_in = evte_pkg::S_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= evte_pkg::S_IDLE;
         busy_ff    <= '0;
         pend_ff    <= 1'b0;
         out_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         cnt_ff     <= '0;
         idx_ff     <= '0;
         for (int i = 0; i < CUR_N; i++) begin
            cur_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         busy_ff    <= busy_in;
         pend_ff    <= pend_in;
         out_vld_ff <= out_vld_in;
         found_ff   <= found_in;
         cnt_ff     <= cnt_in;
         idx_ff     <= idx_in;
         if (cur_we) begin
            cur_ff[cur_wa] <= cur_wd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_tuser;
         tg_ff  <= req_tdata[3:0];
         ev_ff  <= req_tdata[19:4];
         dur_ff <= req_tdata[35:20];
         now_ff <= req_tdata[67:36];
      end
      free_ff     <= free_in;
      pend_tg_ff  <= pend_tg_in;
      pend_val_ff <= pend_val_in;
      v_ff        <= v_in;
      ease_ff     <= ease_in;
      p_ff        <= p_in;
      out_last_ff <= out_last_in;
      out_tg_ff   <= out_tg_in;
      out_val_ff  <= out_val_in;
   end

   // slot table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[idx_ff];
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, out_val_ff, out_tg_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

>>> tb/sv/tb_top.sv
// testbench for eased_value_tween_engine: random and directed start, tick and set requests
// with a built-in predictor of the slot table, checked against the result stream
// depends on evte_pkg and the engine rtl
module tb_top;

   localparam int NSLOT = 16;
   localparam int NTGT = 16;
   localparam int LIMIT = 2000000;

   typedef struct packed {
      logic [1:0]  action;
      logic [3:0]  target;
      logic [15:0] end_value;
      logic [15:0] duration;
      logic [31:0] now;
   } tween_req_type;

   typedef struct packed {
      logic [3:0]  target;
      logic [15:0] value;
      logic        last;
   } tween_upd_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [71:0] req_tdata;   // target, end_value, duration, now, zero pad
   logic [1:0]  req_tuser;   // action
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;   // out_target, out_value, zero pad
   logic        rsp_tlast;

   eased_value_tween_engine uut (.*);

   // predictor state
   logic        p_busy [NSLOT];
   logic [3:0]  p_tgt [NSLOT];
   logic [15:0] p_sv [NSLOT];
   logic [15:0] p_ev [NSLOT];
   logic [31:0] p_st [NSLOT];
   logic [31:0] p_et [NSLOT];
   logic [15:0] p_cur [NTGT];

   tween_req_type pending_reqs[$];
   tween_upd_type expected_upds[$];
   int    mismatches = 0;
   int    cycles = 0;
   bit    quiet = 0;
   bit    hold_for_drain = 0;
   int    req_gap = 0;
   int    rsp_gap = 0;
   bit    stim_done = 0;

   function automatic logic [15:0] ease_value(logic [15:0] sv, logic [15:0] ev,
                                              logic [31:0] dt, logic [31:0] span);
      longint unsigned t;
      longint ease;
      longint prod;
      longint delta;
      t = ({32'd0, dt} << 16) / {32'd0, span};
      ease = longint'(t * (64'd131072 - t));
      prod = ease * (longint'($signed(ev)) - longint'($signed(sv)));
      delta = (prod + (64'sd1 <<< 31)) >>> 32;
      return 16'(longint'($signed(sv)) + delta);
   endfunction

   task automatic predict_tween(input tween_req_type r);
      int i;
      int n;
      int free_slot;
      logic [15:0] cur;
      logic [15:0] v;
      logic [31:0] dt;
      logic [31:0] span;
      logic [32:0] et;
      tween_upd_type u;
      n = 0;
      case (r.action)
         evte_pkg::ACT_START: begin
            cur = p_cur[r.target];
            for (i = 0; i < NSLOT; i++) begin
               if (p_busy[i] && p_tgt[i] == r.target) begin
                  if (p_et[i] > r.now) begin
                     p_et[i] = r.now;
                     p_ev[i] = cur;
                  end
                  if (p_st[i] >= r.now || p_st[i] >= p_et[i]) p_busy[i] = 0;
               end
            end
            free_slot = -1;
            for (i = NSLOT - 1; i >= 0; i--) if (!p_busy[i]) free_slot = i;
            if (free_slot >= 0) begin
               et = {1'b0, r.now} + {17'd0, r.duration};
               if (et[32]) et = 33'h0_FFFF_FFFF;
               p_busy[free_slot] = 1;
               p_tgt[free_slot] = r.target;
               p_sv[free_slot] = cur;
               p_ev[free_slot] = r.end_value;
               p_st[free_slot] = r.now;
               p_et[free_slot] = et[31:0];
            end
         end
         evte_pkg::ACT_TICK: begin
            for (i = 0; i < NSLOT; i++) begin
               if (p_busy[i] && r.now >= p_st[i]) begin
                  dt = r.now - p_st[i];
                  span = p_et[i] - p_st[i];
                  if (span == 0 || dt >= span) begin
                     v = p_ev[i];
                     p_busy[i] = 0;
                  end else begin
                     v = ease_value(p_sv[i], p_ev[i], dt, span);
                  end
                  p_cur[p_tgt[i]] = v;
                  if (n < evte_pkg::MAX_RESULTS) begin
                     u.target = p_tgt[i];
                     u.value = v;
                     u.last = 0;
                     expected_upds.push_back(u);
                     n++;
                  end
               end
            end
            if (n > 0) expected_upds[$].last = 1;
         end
         evte_pkg::ACT_SET: begin
            p_cur[r.target] = r.end_value;
         end
         default: begin
         end
      endcase
   endtask

   function automatic tween_req_type make_req(logic [1:0] a, logic [3:0] tg, logic [15:0] ev,
                                              logic [15:0] d, logic [31:0] now);
      tween_req_type r;
      r.action = a;
      r.target = tg;
      r.end_value = ev;
      r.duration = d;
      r.now = now;
      return r;
   endfunction

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= '0;
         req_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid && req_tready) predict_tween({req_tuser, req_tdata[67:0]} === 'x ?
            '0 : tween_req_type'({req_tuser, req_tdata[3:0], req_tdata[19:4], req_tdata[35:20],
            req_tdata[67:36]}));
         if (req_gap > 0) begin
            req_tvalid <= 0;
            req_gap <= req_gap - 1;
         end else if (pending_reqs.size() > 0 && !(hold_for_drain && expected_upds.size() > 0
                      && !(req_tvalid && req_tready))) begin
            tween_req_type r;
            r = pending_reqs.pop_front();
            req_tvalid <= 1;
            req_tuser <= r.action;
            req_tdata <= {4'd0, r.now, r.duration, r.end_value, r.target};
            if (!quiet && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 6);
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // monitor and scoreboard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         rsp_tready <= 0;
         rsp_gap <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            tween_upd_type e;
            if (expected_upds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result target=%0d value=%h last=%b",
                           rsp_tdata[3:0], rsp_tdata[19:4], rsp_tlast);
            end else begin
               e = expected_upds.pop_front();
               if (rsp_tdata[3:0] !== e.target || rsp_tdata[19:4] !== e.value ||
                   rsp_tlast !== e.last) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch exp target=%0d value=%h last=%b got %0d %h %b",
                              e.target, e.value, e.last, rsp_tdata[3:0], rsp_tdata[19:4],
                              rsp_tlast);
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_tready <= 0;
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_tready <= 1;
            if (!quiet && $urandom_range(0, 5) == 0) rsp_gap <= $urandom_range(1, 6);
         end
      end
   end

   // stimulus
   initial begin
      int i;
      int k;
      int j;
      logic [31:0] clk_now;
      logic [3:0] tg;
      for (i = 0; i < NSLOT; i++) p_busy[i] = 0;
      for (i = 0; i < NTGT; i++) p_cur[i] = '0;
      reset = 1;
      repeat (11) @(posedge clock);
      reset <= 0;

      // directed: extremes, zero duration, tick before start, overflow, overfull table
      pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'd0, 16'h0, 16'h0, 32'd0));
      pending_reqs.push_back(make_req(evte_pkg::ACT_SET, 4'd15, 16'h8000, 16'hFFFF,
                                      32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(evte_pkg::ACT_START, 4'd15, 16'h7FFF, 16'd100, 32'd10));
      pending_reqs.push_back(make_req(evte_pkg::ACT_START, 4'd0, 16'h8000, 16'd0, 32'd20));
      pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'd0, 16'h0, 16'h0, 32'd5));
      pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'd0, 16'h0, 16'h0, 32'd60));
      pending_reqs.push_back(make_req(evte_pkg::ACT_START, 4'd15, 16'h0100, 16'd50, 32'd70));
      pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'd0, 16'h0, 16'h0, 32'd95));
      pending_reqs.push_back(make_req(evte_pkg::ACT_START, 4'd3, 16'h1234, 16'hFFFF,
                                      32'hFFFF_FF00));
      pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'd0, 16'h0, 16'h0, 32'hFFFF_FFF0));
      pending_reqs.push_back(make_req(2'd3, 4'd5, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF));
      pending_reqs.push_back(make_req(evte_pkg::ACT_START, 4'd3, 16'h0, 16'd1, 32'hFFFF_FFFF));
      for (i = 0; i < 17; i++)
         pending_reqs.push_back(make_req(evte_pkg::ACT_START, 4'(i), 16'(i * 977), 16'd40,
                                         32'd1000));
      pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'd0, 16'h0, 16'h0, 32'd1010));
      pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'd0, 16'h0, 16'h0, 32'd1100));
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_upds.size() == 0);
      repeat (600) @(posedge clock);

      // random: timelines of starts, sets and ticks with advancing time
      clk_now = $urandom;
      for (k = 0; k < 280; k++) begin
         if (k == 200) begin
            hold_for_drain = 1;
            wait (pending_reqs.size() == 0 && !req_tvalid && expected_upds.size() == 0);
            hold_for_drain = 0;
         end
         if (k == 240) quiet = 1;
         j = $urandom_range(0, 9);
         tg = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 3));
         if (j < 4) begin
            pending_reqs.push_back(make_req(evte_pkg::ACT_START, tg, 16'($urandom),
               $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)),
               $urandom_range(0, 7) == 0 ? clk_now + $urandom_range(0, 20) : clk_now));
         end else if (j < 5) begin
            pending_reqs.push_back(make_req(evte_pkg::ACT_SET, tg, 16'($urandom),
                                            16'($urandom), $urandom));
         end else if (j < 6 && $urandom_range(0, 3) == 0) begin
            pending_reqs.push_back(make_req(2'd3, tg, 16'($urandom), 16'($urandom), $urandom));
         end else begin
            clk_now = $urandom_range(0, 15) == 0 ? $urandom : clk_now + $urandom_range(0, 8);
            pending_reqs.push_back(make_req(evte_pkg::ACT_TICK, 4'($urandom), 16'($urandom),
                                            16'($urandom), clk_now));
         end
      end
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_upds.size() == 0);
      repeat (600) @(posedge clock);
      if (mismatches == 0 && expected_upds.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end
endmodule

>>> eased_value_tween_engine.f
design/evte_pkg.sv
design/evte_div.sv
design/eased_value_tween_engine.sv
tb/sv/tb_top.sv
